// ===== rtl/ipacl_pkg.sv =====
// ---------------------------------------------------------------------------
// ipacl_pkg
// Shared types, codes and helpers of the IPv4 prefix access control list.
// ---------------------------------------------------------------------------
package ipacl_pkg;

    // field widths
    localparam int ADDR_BITS = 32;
    localparam int PLEN_W    = 6;
    localparam int KIND_W    = 2;

    // default table depth
    localparam int MAX_RULES_DEF = 64;

    // operation codes
    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_CHECK = 1'b1;

    // rule kinds for add
    localparam logic [KIND_W-1:0] RULE_DEFAULT = 2'd0;
    localparam logic [KIND_W-1:0] RULE_DENY    = 2'd1;
    localparam logic [KIND_W-1:0] RULE_ALLOW   = 2'd2;

    // longest legal prefix
    localparam logic [PLEN_W-1:0] PLEN_MAX = PLEN_W'(ADDR_BITS);

    // classified command handed from front to back
    typedef struct packed {
        logic                 op;
        logic [ADDR_BITS-1:0] addr;
        logic [PLEN_W-1:0]    plen;
        logic                 allow;
    } t_cmd;

    // one stored rule
    typedef struct packed {
        logic [ADDR_BITS-1:0] addr;
        logic [PLEN_W-1:0]    plen;
        logic                 allow;
    } t_rule;

    // one result transaction
    typedef struct packed {
        logic allowed;
        logic matched;
        logic status;
    } t_res;

    // leading-ones mask for a prefix length of 0..32
    function automatic logic [ADDR_BITS-1:0] prefix_mask(input logic [PLEN_W-1:0] plen);
        logic [ADDR_BITS-1:0] mask;
        if (plen == '0) begin
            mask = '0;
        end else begin
            mask = {ADDR_BITS{1'b1}} << (PLEN_MAX - plen);
        end
        return mask;
    endfunction

endpackage

// ===== rtl/ipacl_fifo2.sv =====
// ---------------------------------------------------------------------------
// ipacl_fifo2
// Two-entry register queue with push/full and pop/empty handshakes.
// ---------------------------------------------------------------------------
module ipacl_fifo2 #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wdata,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_empty
);

    logic [WIDTH-1:0] r_data [2];
    logic             r_wptr;
    logic             r_rptr;
    logic [1:0]       r_cnt;
    logic             w_do_push;
    logic             w_do_pop;

    assign o_full    = (r_cnt == 2'd2);
    assign o_empty   = (r_cnt == 2'd0);
    assign o_rdata   = r_data[r_rptr];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;

    // storage, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_data[r_wptr] <= i_wdata;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (w_do_push) begin
                r_wptr <= ~r_wptr;
            end
            if (w_do_pop) begin
                r_rptr <= ~r_rptr;
            end
            case ({w_do_push, w_do_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ===== rtl/ipacl_front.sv =====
// ---------------------------------------------------------------------------
// ipacl_front
// Accepts input transactions, resolves rule verdict and prefix clamp, and
// queues the classified commands for the back end.
// ---------------------------------------------------------------------------
module ipacl_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic                                i_opcode,
    input  logic [ipacl_pkg::ADDR_BITS-1:0]     i_address,
    input  logic [ipacl_pkg::PLEN_W-1:0]        i_prefix_length,
    input  logic [ipacl_pkg::KIND_W-1:0]        i_rule_kind,
    input  logic                                i_default_allow,
    input  logic                                i_cmd_pop,
    output ipacl_pkg::t_cmd                     o_cmd,
    output logic                                o_cmd_valid
);

    ipacl_pkg::t_cmd w_cmd;
    logic            w_cmd_empty;
    logic [$bits(ipacl_pkg::t_cmd)-1:0] w_rdata;

    // classify: clamp prefix, pick allow bit
    always_comb begin
        w_cmd.op   = i_opcode;
        w_cmd.addr = i_address;
        if (i_prefix_length > ipacl_pkg::PLEN_MAX) begin
            w_cmd.plen = ipacl_pkg::PLEN_MAX;
        end else begin
            w_cmd.plen = i_prefix_length;
        end
        case (i_rule_kind)
            ipacl_pkg::RULE_DENY:  w_cmd.allow = 1'b0;
            ipacl_pkg::RULE_ALLOW: w_cmd.allow = 1'b1;
            default:               w_cmd.allow = i_default_allow;
        endcase
    end

    // command queue toward the back end
    ipacl_fifo2 #(
        .WIDTH ($bits(ipacl_pkg::t_cmd))
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_wdata (w_cmd),
        .o_full  (full),
        .i_pop   (i_cmd_pop),
        .o_rdata (w_rdata),
        .o_empty (w_cmd_empty)
    );

    assign o_cmd       = ipacl_pkg::t_cmd'(w_rdata);
    assign o_cmd_valid = !w_cmd_empty;

endmodule

// ===== rtl/ipacl_back.sv =====
// ---------------------------------------------------------------------------
// ipacl_back
// Rule table and scan engine: appends rules, scans newest first one entry
// per cycle, and queues results.
// ---------------------------------------------------------------------------
module ipacl_back #(
    parameter int MAX_RULES = ipacl_pkg::MAX_RULES_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_default_allow,
    input  ipacl_pkg::t_cmd i_cmd,
    input  logic            i_cmd_valid,
    output logic            o_cmd_pop,
    input  logic            pop,
    output logic            empty,
    output ipacl_pkg::t_res o_res
);

    localparam int IDX_W = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
    localparam int CNT_W = $clog2(MAX_RULES + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_RULES);

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } t_state;

    t_state                          r_state, n_state;
    logic [CNT_W-1:0]                r_count, n_count;
    logic [IDX_W-1:0]                r_idx, n_idx;
    logic [ipacl_pkg::ADDR_BITS-1:0] r_qaddr, n_qaddr;
    ipacl_pkg::t_rule                r_rd;
    ipacl_pkg::t_rule                r_mem [MAX_RULES];

    logic             w_mem_we;
    ipacl_pkg::t_res  w_res;
    logic             w_res_push;
    logic             w_res_full;
    logic             w_hit;
    logic [ipacl_pkg::ADDR_BITS-1:0] w_mask;
    logic [$bits(ipacl_pkg::t_res)-1:0] w_res_rdata;

    // masked compare of queried address against the rule just read
    assign w_mask = ipacl_pkg::prefix_mask(r_rd.plen);
    assign w_hit  = ((r_qaddr ^ r_rd.addr) & w_mask) == '0;

    // next-state logic
    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_idx      = r_idx;
        n_qaddr    = r_qaddr;
        o_cmd_pop  = 1'b0;
        w_mem_we   = 1'b0;
        w_res_push = 1'b0;
        w_res      = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid && !w_res_full) begin
                    o_cmd_pop = 1'b1;
                    if (i_cmd.op == ipacl_pkg::OP_ADD) begin
                        w_res_push = 1'b1;
                        if (r_count >= CNT_MAX) begin
                            w_res.status = 1'b1;
                        end else begin
                            w_mem_we = 1'b1;
                            n_count  = r_count + CNT_W'(1);
                        end
                    end else begin
                        n_qaddr = i_cmd.addr;
                        if (r_count == '0) begin
                            w_res_push    = 1'b1;
                            w_res.allowed = i_default_allow;
                        end else begin
                            n_idx   = IDX_W'(r_count - CNT_W'(1));
                            n_state = S_SCAN;
                        end
                    end
                end
            end
            S_SCAN: begin
                if (w_hit) begin
                    w_res_push    = 1'b1;
                    w_res.allowed = r_rd.allow;
                    w_res.matched = 1'b1;
                    n_state       = S_IDLE;
                end else if (r_idx == '0) begin
                    w_res_push    = 1'b1;
                    w_res.allowed = i_default_allow;
                    n_state       = S_IDLE;
                end else begin
                    n_idx = r_idx - IDX_W'(1);
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state and scan registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_idx   <= n_idx;
        end
        r_qaddr <= n_qaddr;
    end

    // rule table: append at fill count, registered read of next index
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[r_count[IDX_W-1:0]] <= ipacl_pkg::t_rule'{
                addr:  i_cmd.addr,
                plen:  i_cmd.plen,
                allow: i_cmd.allow
            };
        end
        r_rd <= r_mem[n_idx];
    end

    // result queue toward the consumer
    ipacl_fifo2 #(
        .WIDTH ($bits(ipacl_pkg::t_res))
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_wdata (w_res),
        .o_full  (w_res_full),
        .i_pop   (pop),
        .o_rdata (w_res_rdata),
        .o_empty (empty)
    );

    assign o_res = ipacl_pkg::t_res'(w_res_rdata);

endmodule

// ===== rtl/ipv4_prefix_acl_filter_unit.sv =====
// ---------------------------------------------------------------------------
// ipv4_prefix_acl_filter_unit
// IPv4 prefix access control list with a decoupled front and back end.
// ---------------------------------------------------------------------------
// Input channel: a transaction is taken when push is high and full is low.
// Opcode add appends a rule (prefix clamped to 32, verdict from rule kind or
// the current default); opcode check looks up an address.
// Result channel: the oldest result sits on o_allowed/o_matched/o_status
// while empty is low and leaves when pop is high.
// A two-entry command queue and a two-entry result queue decouple both
// sides; the block keeps taking input while results wait, until both fill.
// A check scans the rule table newest first, one rule table read per cycle,
// examining up to MAX_RULES rules and stopping at the first match.
// Reset clears the rule count (table empty) and sets default_allow to 1.
// When the consumer stalls the result queue fills, the back end stops, then
// the command queue fills and full rises. default_allow is written through
// i_cfg_we/i_cfg_wdata; the user must do so only while idle (not enforced).
// ---------------------------------------------------------------------------
module ipv4_prefix_acl_filter_unit #(
    parameter int MAX_RULES = ipacl_pkg::MAX_RULES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            push,
    output logic                            full,
    input  logic                            i_opcode,
    input  logic [ipacl_pkg::ADDR_BITS-1:0] i_address,
    input  logic [ipacl_pkg::PLEN_W-1:0]    i_prefix_length,
    input  logic [ipacl_pkg::KIND_W-1:0]    i_rule_kind,
    output logic                            empty,
    input  logic                            pop,
    output logic                            o_allowed,
    output logic                            o_matched,
    output logic                            o_status,
    input  logic                            i_cfg_we,
    input  logic                            i_cfg_wdata
);

    logic            r_default_allow;
    ipacl_pkg::t_cmd w_cmd;
    logic            w_cmd_valid;
    logic            w_cmd_pop;
    ipacl_pkg::t_res w_res;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_default_allow <= 1'b1;
        end else if (i_cfg_we) begin
            r_default_allow <= i_cfg_wdata;
        end
    end

    // front end: accept and classify
    ipacl_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_opcode        (i_opcode),
        .i_address       (i_address),
        .i_prefix_length (i_prefix_length),
        .i_rule_kind     (i_rule_kind),
        .i_default_allow (r_default_allow),
        .i_cmd_pop       (w_cmd_pop),
        .o_cmd           (w_cmd),
        .o_cmd_valid     (w_cmd_valid)
    );

    // back end: rule table and scan
    ipacl_back #(
        .MAX_RULES (MAX_RULES)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_default_allow (r_default_allow),
        .i_cmd           (w_cmd),
        .i_cmd_valid     (w_cmd_valid),
        .o_cmd_pop       (w_cmd_pop),
        .pop             (pop),
        .empty           (empty),
        .o_res           (w_res)
    );

    assign o_allowed = w_res.allowed;
    assign o_matched = w_res.matched;
    assign o_status  = w_res.status;

endmodule
